/* hdl/sst_pkg.sv */
// Shared types and constants for the script source tokenizer.
package sst_pkg;

	localparam int VALUE_BITS_DEFAULT = 64;

	typedef enum logic [1:0] {
		REC_TEXT  = 2'd0,
		REC_TOKEN = 2'd1,
		REC_ERROR = 2'd2
	} rec_kind_t;

	typedef enum logic [2:0] {
		TOK_OP     = 3'd0,
		TOK_IDENT  = 3'd1,
		TOK_INT    = 3'd2,
		TOK_STRING = 3'd3,
		TOK_FLOAT  = 3'd4
	} tok_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_NEWLINE   = 3'd1,
		ERR_ESCAPE    = 3'd2,
		ERR_UNTERM    = 3'd3,
		ERR_EARLY_END = 3'd4,
		ERR_OVERFLOW  = 3'd5,
		ERR_POINT     = 3'd6
	} err_code_t;

	// one result record
	typedef struct packed {
		rec_kind_t rk;
		tok_kind_t tk;
		logic [23:0] ops;
		logic [63:0] iv;
		logic [7:0] tb;
		logic sb;
		logic sa;
		err_code_t err;
	} rec_t;

endpackage

/* hdl/script_source_tokenizer.sv */
// Script source tokenizer: byte-serial lexer for C-style script text.
//
// Each accepted source byte is scanned in the cycle it is taken. Its zero to three result
// records (text bytes, token complete, error) load into a three-entry record queue. The first
// record shows on the output the cycle after the byte is taken, and the rest leave one per
// cycle unless the output stalls. Input stalls while the queue holds anything other than a
// final record that leaves in this cycle. Bytes that yield at most one record follow back
// to back unless the output stalls; after other bytes, the next byte waits until the final
// record leaves. The scanner state updates once per byte; the decimal multiply-by-ten is the
// longest path. Value width follows VALUE_BITS; int_value is sign-extended to 64 bits.
module script_source_tokenizer #(
	parameter int VALUE_BITS = sst_pkg::VALUE_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  record_kind,
	output logic [2:0]  token_kind,
	output logic [23:0] operator_chars,
	output logic [63:0] int_value,
	output logic [7:0]  text_byte,
	output logic        space_before,
	output logic        space_after,
	output logic [2:0]  error_code,
	output logic        last_of_run
);
	import sst_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_OP, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_IDENT, M_NFIRST,
		M_HEX, M_BIN, M_DEC, M_FLOAT, M_STR, M_ESC, M_DESC, M_SAFTER
	} mode_t;

	localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] VLIM = VMAX / 10;
	localparam logic [VALUE_BITS-1:0] VREM = VMAX % 10;
	localparam int HEX_LIM = VALUE_BITS / 4;

	// scanner state
	mode_t mode_q;
	logic [23:0] pend_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [6:0] cnt_q;
	logic [7:0] esc_q;
	logic sb_q, saq_q, sat_q;

	// record queue: entry plus last flag
	typedef struct packed { rec_t r; logic last; } qent_t;
	qent_t q_q [3];
	logic [1:0] qn_q;

	logic take, pop;
	assign pop = out_valid && !out_stall;
	assign out_valid = (qn_q != 2'd0);
	assign in_stall = (qn_q != 2'd0) && !(qn_q == 2'd1 && pop);
	assign take = in_valid && !in_stall;

	// next-state and record generation
	mode_t m;
	logic [23:0] pend;
	logic [VALUE_BITS-1:0] acc;
	logic [6:0] cnt;
	logic [7:0] esc;
	logic sb, saq, sat;
	rec_t recs [3];
	logic [1:0] nrec;
	logic rescan;
	logic [7:0] b;
	logic ws, dig, alp;
	logic [3:0] hv;
	logic hok;
	logic [VALUE_BITS-1:0] dv;
	logic [7:0] c0;

	function automatic rec_t mk(rec_kind_t rk, tok_kind_t tk, logic [23:0] ops,
			logic [63:0] iv, logic [7:0] tb, logic s_b, logic s_a, err_code_t e);
		rec_t r;
		r.rk = rk; r.tk = tk; r.ops = ops; r.iv = iv; r.tb = tb;
		r.sb = s_b; r.sa = s_a; r.err = e;
		return r;
	endfunction

	always_comb begin
		m = mode_q; pend = pend_q; acc = acc_q; cnt = cnt_q; esc = esc_q;
		sb = sb_q; saq = saq_q; sat = sat_q;
		nrec = 2'd0; rescan = 1'b0;
		for (int i = 0; i < 3; i++) recs[i] = '0;
		b = source_byte;
		ws = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
		dig = (b >= "0" && b <= "9");
		alp = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		hok = 1'b1; hv = b[3:0];
		if (dig) hv = b[3:0];
		else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) hv = b[3:0] + 4'd9;
		else hok = 1'b0;
		dv = VALUE_BITS'(b[3:0]);
		c0 = pend_q[7:0];
		// a step runs the scanner at most twice (slash, number start, decimal escape)
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 0 || rescan) begin
				logic again;
				logic finish;
				tok_kind_t fk;
				logic [63:0] fiv;
				logic [23:0] fops;
				logic fsa;
				logic start;
				again = 1'b0; finish = 1'b0; start = 1'b0;
				fk = TOK_OP; fiv = '0; fops = '0; fsa = ws;
				unique case (m)
					M_IDLE: start = 1'b1;
					M_OP: begin
						logic ext;
						c0 = pend[7:0];
						ext = 1'b0;
						if (cnt == 7'd1) begin
							unique case (c0)
								"=", "!", "*", "%", "^", "/": ext = (b == "=");
								":": ext = (b == ":");
								"<", ">", "&", "|", "+", "-": ext = (b == "=") || (b == c0);
								default: ext = 1'b0;
							endcase
						end else if (cnt == 7'd2) begin
							ext = ((pend[15:0] == {8'h3C, 8'h3C}) ||
								(pend[15:0] == {8'h3E, 8'h3E})) && (b == "=");
						end
						if (ext) begin
							if (cnt == 7'd1) pend[15:8] = b; else pend[23:16] = b;
							cnt = cnt + 7'd1;
						end else begin
							finish = 1'b1; fk = TOK_OP; fops = pend; start = 1'b1;
						end
					end
					M_SLASH: begin
						if (b == "/") m = M_LINE;
						else if (b == "*") m = M_BLOCK;
						else begin m = M_OP; again = 1'b1; end
					end
					M_LINE: if (b == 8'h0A) begin m = M_IDLE; sb = 1'b0; end
					M_BLOCK: if (b == "*") m = M_BSTAR;
					M_BSTAR: begin
						if (b == "/") begin m = M_IDLE; sb = 1'b0; end
						else if (b != "*") m = M_BLOCK;
					end
					M_IDENT: begin
						if (alp || dig || b == "_") begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
						end else begin
							finish = 1'b1; fk = TOK_IDENT; start = 1'b1;
						end
					end
					M_NFIRST: begin
						if (b == "x" || b == "b") begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
							acc = '0; cnt = '0;
							m = (b == "x") ? M_HEX : M_BIN;
						end else begin
							m = M_DEC; again = 1'b1;
						end
					end
					M_HEX, M_BIN: begin
						logic ok;
						ok = (m == M_HEX) ? hok : (b == "0" || b == "1");
						if (ok) begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
							if (cnt != 7'd127) cnt = cnt + 7'd1;
							if (m == M_HEX) acc = {acc[VALUE_BITS-5:0], hv};
							else acc = {acc[VALUE_BITS-2:0], b[0]};
						end else if ((m == M_HEX) ? (32'(cnt) > HEX_LIM)
								: (32'(cnt) > VALUE_BITS)) begin
							recs[nrec] = mk(REC_ERROR, TOK_OP, '0, '0, '0, 1'b0, 1'b0,
								ERR_OVERFLOW);
							nrec = nrec + 2'd1;
							m = M_IDLE;
						end else begin
							finish = 1'b1; fk = TOK_INT;
							fiv = 64'($signed(acc)); start = 1'b1;
						end
					end
					M_DEC: begin
						if (dig) begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
							if (sat || acc > VLIM || (acc == VLIM && dv > VREM)) begin
								acc = VMAX; sat = 1'b1;
							end else begin
								acc = (acc << 3) + (acc << 1) + dv;
							end
						end else if (b == ".") begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
							m = M_FLOAT;
						end else begin
							finish = 1'b1; fk = TOK_INT;
							fiv = 64'($signed(acc)); start = 1'b1;
						end
					end
					M_FLOAT: begin
						if (dig) begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
						end else if (b == ".") begin
							recs[nrec] = mk(REC_ERROR, TOK_OP, '0, '0, '0, 1'b0, 1'b0, ERR_POINT);
							nrec = nrec + 2'd1;
							m = M_IDLE;
						end else begin
							finish = 1'b1; fk = TOK_FLOAT; start = 1'b1;
						end
					end
					M_STR: begin
						if (b == 8'h22) begin m = M_SAFTER; cnt = '0; saq = 1'b0; end
						else if (b == 8'h0A) begin
							recs[nrec] = mk(REC_ERROR, TOK_OP, '0, '0, '0, 1'b0, 1'b0,
								ERR_NEWLINE);
							nrec = nrec + 2'd1;
							m = M_IDLE;
						end else if (b == 8'h5C) m = M_ESC;
						else begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
						end
					end
					M_ESC: begin
						logic [7:0] t;
						logic tv;
						m = M_STR; tv = 1'b1; t = b;
						unique case (b)
							8'h5C, 8'h22: t = b;
							"n": t = 8'h0A;
							"r": t = 8'h0D;
							"t": t = 8'h09;
							"0": begin tv = 1'b0; esc = '0; m = M_DESC; end
							default: begin
								tv = 1'b0;
								recs[nrec] = mk(REC_ERROR, TOK_OP, '0, '0, '0, 1'b0, 1'b0,
									ERR_ESCAPE);
								nrec = nrec + 2'd1;
								m = M_IDLE;
							end
						endcase
						if (tv) begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, t, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
						end
					end
					M_DESC: begin
						if (dig) esc = (esc << 3) + (esc << 1) + {4'd0, b[3:0]};
						else begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, esc, 1'b0, 1'b0,
								ERR_NONE);
							nrec = nrec + 2'd1;
							m = M_STR; again = 1'b1;
						end
					end
					M_SAFTER: begin
						if (b == 8'h22) m = M_STR;
						else if (ws) begin
							if (cnt == 7'd0) saq = 1'b1;
							cnt = 7'd1;
						end else begin
							finish = 1'b1; fk = TOK_STRING; fsa = saq; start = 1'b1;
						end
					end
					default: m = M_IDLE;
				endcase
				if (finish) begin
					recs[nrec] = mk(REC_TOKEN, fk, fops, fiv, '0, sb, fsa, ERR_NONE);
					nrec = nrec + 2'd1;
					sb = fsa; m = M_IDLE;
				end
				// open a new token with this byte
				if (start) begin
					if (ws) sb = 1'b1;
					else if (b == 8'h22) m = M_STR;
					else begin
						pend = {16'd0, b}; cnt = 7'd1;
						if (b == "/") m = M_SLASH;
						else if (dig) begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
							acc = VALUE_BITS'(b[3:0]); sat = 1'b0; cnt = '0;
							m = M_NFIRST;
						end else if (alp || b == "_") begin
							recs[nrec] = mk(REC_TEXT, TOK_OP, '0, '0, b, 1'b0, 1'b0, ERR_NONE);
							nrec = nrec + 2'd1;
							m = M_IDENT;
						end else m = M_OP;
					end
				end
				rescan = again;
			end
		end
		// close out at end of source
		if (end_of_source) begin
			unique case (m)
				M_OP: begin
					recs[nrec] = mk(REC_TOKEN, TOK_OP, pend, '0, '0, sb, 1'b0, ERR_NONE);
					nrec = nrec + 2'd1;
				end
				M_IDENT: begin
					recs[nrec] = mk(REC_TOKEN, TOK_IDENT, '0, '0, '0, sb, 1'b0, ERR_NONE);
					nrec = nrec + 2'd1;
				end
				M_SAFTER: begin
					recs[nrec] = mk(REC_TOKEN, TOK_STRING, '0, '0, '0, sb, saq, ERR_NONE);
					nrec = nrec + 2'd1;
				end
				M_SLASH, M_BLOCK, M_BSTAR, M_NFIRST, M_HEX, M_BIN, M_DEC, M_FLOAT: begin
					recs[nrec] = mk(REC_ERROR, TOK_OP, '0, '0, '0, 1'b0, 1'b0, ERR_EARLY_END);
					nrec = nrec + 2'd1;
				end
				M_STR, M_ESC, M_DESC: begin
					recs[nrec] = mk(REC_ERROR, TOK_OP, '0, '0, '0, 1'b0, 1'b0, ERR_UNTERM);
					nrec = nrec + 2'd1;
				end
				default: ;
			endcase
			m = M_IDLE; pend = '0; acc = '0; cnt = '0; esc = '0;
			sb = 1'b0; saq = 1'b0; sat = 1'b0;
		end
	end

	// hold scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= '0; acc_q <= '0; cnt_q <= '0; esc_q <= '0;
			sb_q <= 1'b0; saq_q <= 1'b0; sat_q <= 1'b0;
		end else if (take) begin
			mode_q <= m; pend_q <= pend; acc_q <= acc; cnt_q <= cnt; esc_q <= esc;
			sb_q <= sb; saq_q <= saq; sat_q <= sat;
		end
	end

	// advance the record queue: drop the head, then load a new run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qn_q <= '0;
			for (int i = 0; i < 3; i++) q_q[i] <= '0;
		end else if (take) begin
			qn_q <= nrec;
			for (int i = 0; i < 3; i++) begin
				q_q[i].r <= recs[i];
				q_q[i].last <= (2'(i) == nrec - 2'd1);
			end
		end else if (pop) begin
			qn_q <= qn_q - 2'd1;
			q_q[0] <= q_q[1];
			q_q[1] <= q_q[2];
		end
	end

	assign record_kind    = q_q[0].r.rk;
	assign token_kind     = q_q[0].r.tk;
	assign operator_chars = q_q[0].r.ops;
	assign int_value      = q_q[0].r.iv;
	assign text_byte      = q_q[0].r.tb;
	assign space_before   = q_q[0].r.sb;
	assign space_after    = q_q[0].r.sa;
	assign error_code     = q_q[0].r.err;
	assign last_of_run    = q_q[0].last;

endmodule

/* hdl/sst_checker.sv */
// Port-level checks for the script source tokenizer, bound to the top level.
module sst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  record_kind,
	input logic [7:0]  text_byte,
	input logic [2:0]  error_code,
	input logic        last_of_run
);
	import sst_pkg::*;

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(record_kind) && $stable(text_byte))
		else $error("stalled result changed");

	// error records carry a code, others none
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((record_kind == REC_ERROR) == (error_code != ERR_NONE)))
		else $error("error code mismatch");

	// no input taken while results wait beyond the last one
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> in_stall)
		else $error("input taken mid run");

	// record kind stays within the defined kinds
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (record_kind == REC_TEXT || record_kind == REC_TOKEN ||
			record_kind == REC_ERROR))
		else $error("bad record kind");

endmodule

bind script_source_tokenizer sst_checker u_sst_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .record_kind(record_kind),
	.text_byte(text_byte), .error_code(error_code), .last_of_run(last_of_run)
);

/* verif/script_source_tokenizer_test.sv */
// Self-checking testbench for the script source tokenizer.
module script_source_tokenizer_test;
	import sst_pkg::*;

	localparam int VB = 64;
	localparam logic [63:0] VMASK = (VB == 64) ? {64{1'b1}} : ((64'd1 << VB) - 64'd1);

	typedef enum int {
		S_IDLE, S_OP, S_SLASH, S_LINE, S_BLOCK, S_BSTAR, S_IDENT, S_NFIRST,
		S_HEX, S_BIN, S_DEC, S_FLOAT, S_STR, S_ESC, S_DESC, S_SAFTER
	} lex_mode_t;

	typedef struct packed {
		rec_t r;
		logic last;
	} lex_rec_t;

	typedef struct packed {
		logic [7:0] b;
		logic eos;
	} src_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] source_byte = 8'd0;
	logic end_of_source = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] record_kind;
	logic [2:0] token_kind;
	logic [23:0] operator_chars;
	logic [63:0] int_value;
	logic [7:0] text_byte;
	logic space_before, space_after;
	logic [2:0] error_code;
	logic last_of_run;

	script_source_tokenizer #(.VALUE_BITS(VB)) i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	src_item_t pending_src[$];
	lex_rec_t expected_recs[$];
	int errors = 0;
	bit stim_done = 0;

	// lexer state
	lex_mode_t mode;
	logic [23:0] op_acc;
	logic [63:0] val_acc;
	int dcount;
	logic [7:0] esc_acc;
	logic sp_before, sp_quote, sat;
	lex_rec_t step_recs[$];

	function automatic bit is_space(logic [7:0] b);
		return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
	endfunction
	function automatic bit is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction
	function automatic bit is_letter(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	task automatic push_rec(rec_kind_t rk, tok_kind_t tk, logic [23:0] ops, logic [63:0] iv,
			logic [7:0] tb, logic sb, logic sa, err_code_t err);
		lex_rec_t e;
		if (step_recs.size() >= 3) return;
		e.r.rk = rk; e.r.tk = tk; e.r.ops = ops; e.r.iv = iv; e.r.tb = tb;
		e.r.sb = sb; e.r.sa = sa; e.r.err = err; e.last = 1'b0;
		step_recs.push_back(e);
	endtask

	task automatic put_text(logic [7:0] b);
		push_rec(REC_TEXT, TOK_OP, 0, 0, b, 0, 0, ERR_NONE);
	endtask

	task automatic close_token(tok_kind_t k, logic [23:0] ops, logic [63:0] iv, logic sa);
		push_rec(REC_TOKEN, k, ops, iv, 0, sp_before, sa, ERR_NONE);
		sp_before = sa;
		mode = S_IDLE;
	endtask

	task automatic raise_error(err_code_t c);
		push_rec(REC_ERROR, TOK_OP, 0, 0, 0, 0, 0, c);
		mode = S_IDLE;
	endtask

	function automatic logic [63:0] sign_ext(logic [63:0] v);
		v &= VMASK;
		if (v[VB-1]) v |= ~VMASK;
		return v;
	endfunction

	function automatic bit op_extends(logic [23:0] p, int len, logic [7:0] b);
		logic [7:0] c;
		c = p[7:0];
		if (len == 1) begin
			case (c)
				"=", "!", "*", "%", "^", "/": return b == "=";
				":": return b == ":";
				"<", ">", "&", "|", "+", "-": return b == "=" || b == c;
				default: return 0;
			endcase
		end
		if (len == 2) return (p == {8'd0, "<", "<"} || p == {8'd0, ">", ">"}) && b == "=";
		return 0;
	endfunction

	task automatic begin_token(logic [7:0] b);
		if (is_space(b)) begin
			sp_before = 1;
			return;
		end
		if (b == "\"") begin
			mode = S_STR;
			return;
		end
		op_acc = {16'd0, b};
		dcount = 1;
		if (b == "/") begin
			mode = S_SLASH;
			return;
		end
		if (is_digit(b)) begin
			put_text(b);
			val_acc = b - "0"; sat = 0; dcount = 0;
			mode = S_NFIRST;
			return;
		end
		if (is_letter(b) || b == "_") begin
			put_text(b);
			mode = S_IDENT;
			return;
		end
		mode = S_OP;
	endtask

	function automatic int hex_digit(logic [7:0] b);
		if (is_digit(b)) return b - "0";
		if (b >= "a" && b <= "f") return b - "a" + 10;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		return -1;
	endfunction

	// scan one byte; return 1 when it must be scanned again
	task automatic scan_byte(logic [7:0] b, output bit again);
		logic sp;
		logic [63:0] maxv, d;
		int h;
		sp = is_space(b);
		maxv = VMASK >> 1;
		again = 0;
		case (mode)
			S_IDLE: begin_token(b);
			S_OP: begin
				if (dcount < 3 && op_extends(op_acc, dcount, b)) begin
					op_acc |= 24'(b) << (8 * dcount);
					dcount++;
				end else begin
					close_token(TOK_OP, op_acc, 0, sp);
					begin_token(b);
				end
			end
			S_SLASH: begin
				if (b == "/") mode = S_LINE;
				else if (b == "*") mode = S_BLOCK;
				else begin
					mode = S_OP;
					again = 1;
				end
			end
			S_LINE: if (b == 8'd10) begin
				mode = S_IDLE; sp_before = 0;
			end
			S_BLOCK: if (b == "*") mode = S_BSTAR;
			S_BSTAR: begin
				if (b == "/") begin
					mode = S_IDLE; sp_before = 0;
				end else if (b != "*") mode = S_BLOCK;
			end
			S_IDENT: begin
				if (is_letter(b) || is_digit(b) || b == "_") put_text(b);
				else begin
					close_token(TOK_IDENT, 0, 0, sp);
					begin_token(b);
				end
			end
			S_NFIRST: begin
				if (b == "x" || b == "b") begin
					put_text(b); val_acc = 0; dcount = 0;
					mode = (b == "x") ? S_HEX : S_BIN;
				end else begin
					mode = S_DEC;
					again = 1;
				end
			end
			S_HEX, S_BIN: begin
				h = hex_digit(b);
				if (mode == S_BIN && b != "0" && b != "1") h = -1;
				if (h >= 0) begin
					put_text(b);
					if (dcount < 127) dcount++;
					val_acc = (mode == S_HEX) ? (((val_acc << 4) | 64'(h)) & VMASK)
						: (((val_acc << 1) | 64'(h)) & VMASK);
				end else if (dcount > ((mode == S_HEX) ? VB / 4 : VB)) begin
					raise_error(ERR_OVERFLOW);
				end else begin
					close_token(TOK_INT, 0, sign_ext(val_acc), sp);
					begin_token(b);
				end
			end
			S_DEC: begin
				if (is_digit(b)) begin
					d = b - "0";
					put_text(b);
					if (sat || val_acc > (maxv - d) / 10) begin
						val_acc = maxv; sat = 1;
					end else val_acc = val_acc * 10 + d;
				end else if (b == ".") begin
					put_text(b); mode = S_FLOAT;
				end else begin
					close_token(TOK_INT, 0, sign_ext(val_acc), sp);
					begin_token(b);
				end
			end
			S_FLOAT: begin
				if (is_digit(b)) put_text(b);
				else if (b == ".") raise_error(ERR_POINT);
				else begin
					close_token(TOK_FLOAT, 0, 0, sp);
					begin_token(b);
				end
			end
			S_STR: begin
				if (b == "\"") begin
					mode = S_SAFTER; dcount = 0; sp_quote = 0;
				end else if (b == 8'd10) raise_error(ERR_NEWLINE);
				else if (b == "\\") mode = S_ESC;
				else put_text(b);
			end
			S_ESC: begin
				mode = S_STR;
				case (b)
					"\\": put_text("\\");
					"\"": put_text("\"");
					"n": put_text(8'd10);
					"r": put_text(8'd13);
					"t": put_text(8'd9);
					"0": begin
						esc_acc = 0; mode = S_DESC;
					end
					default: raise_error(ERR_ESCAPE);
				endcase
			end
			S_DESC: begin
				if (is_digit(b)) esc_acc = 8'(esc_acc * 10 + (b - "0"));
				else begin
					put_text(esc_acc);
					mode = S_STR;
					again = 1;
				end
			end
			S_SAFTER: begin
				if (b == "\"") mode = S_STR;
				else if (sp) begin
					if (dcount == 0) sp_quote = 1;
					dcount = 1;
				end else begin
					close_token(TOK_STRING, 0, 0, sp_quote);
					begin_token(b);
				end
			end
			default: mode = S_IDLE;
		endcase
	endtask

	task automatic clear_lexer();
		mode = S_IDLE; op_acc = 0; val_acc = 0; dcount = 0; esc_acc = 0;
		sp_before = 0; sp_quote = 0; sat = 0;
	endtask

	// predict the records of one accepted byte
	task automatic predict_byte(logic [7:0] b, logic eos);
		bit again;
		int guard;
		step_recs.delete();
		guard = 0;
		scan_byte(b, again);
		while (again && guard < 4) begin
			guard++;
			scan_byte(b, again);
		end
		if (eos) begin
			case (mode)
				S_OP: close_token(TOK_OP, op_acc, 0, 0);
				S_IDENT: close_token(TOK_IDENT, 0, 0, 0);
				S_SAFTER: close_token(TOK_STRING, 0, 0, sp_quote);
				S_SLASH, S_BLOCK, S_BSTAR, S_NFIRST, S_HEX, S_BIN, S_DEC, S_FLOAT:
					raise_error(ERR_EARLY_END);
				S_STR, S_ESC, S_DESC: raise_error(ERR_UNTERM);
				default: ;
			endcase
			clear_lexer();
		end
		if (step_recs.size() > 0) step_recs[step_recs.size()-1].last = 1'b1;
		foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	// driver: bursts with gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_byte(source_byte, end_of_source);
				void'(pending_src.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_src.size() > ((in_valid && !in_stall) ? 0 : 0)) begin
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 30);
					end
					burst_left--;
					if (burst_left == 0 && $urandom_range(0, 2) == 0)
						gap_left = $urandom_range(1, 5);
					in_valid <= 1'b1;
					source_byte <= pending_src[0].b;
					end_of_source <= pending_src[0].eos;
				end else in_valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stall pattern
	int stall_phase = 0;
	always @(posedge clk) begin
		lex_rec_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_recs.size() == 0) begin
					report_mismatch("unexpected record_kind", record_kind, 0);
				end else begin
					e = expected_recs.pop_front();
					if (record_kind !== e.r.rk) report_mismatch("record_kind", record_kind, e.r.rk);
					if (token_kind !== e.r.tk) report_mismatch("token_kind", token_kind, e.r.tk);
					if (operator_chars !== e.r.ops)
						report_mismatch("operator_chars", operator_chars, e.r.ops);
					if (int_value !== e.r.iv) report_mismatch("int_value", int_value, e.r.iv);
					if (text_byte !== e.r.tb) report_mismatch("text_byte", text_byte, e.r.tb);
					if (space_before !== e.r.sb)
						report_mismatch("space_before", space_before, e.r.sb);
					if (space_after !== e.r.sa) report_mismatch("space_after", space_after, e.r.sa);
					if (error_code !== e.r.err) report_mismatch("error_code", error_code, e.r.err);
					if (last_of_run !== e.last) report_mismatch("last_of_run", last_of_run, e.last);
				end
			end
			stall_phase = (stall_phase + 1) % 64;
			if (stall_phase < 20) out_stall <= 1'b0;
			else if (stall_phase < 40) out_stall <= ($urandom_range(0, 2) == 0);
			else out_stall <= ($urandom_range(0, 1) == 0);
		end
	end

	task automatic add_text(string s, bit eos_at_end);
		for (int i = 0; i < s.len(); i++) begin
			src_item_t it;
			it.b = s[i];
			it.eos = eos_at_end && (i == s.len() - 1);
			pending_src.push_back(it);
		end
	endtask

	function automatic string pick_fragment();
		string frags[$] = '{"abc", "_x9", "0x1F", "0b101", "12345", "3.14", "\"hi\"",
			"\"a\\n\\t\\\\\\\"\"", "\"\\065x\"", "\"p\" \"q\"", "<<=", ">>=", "==", "!=",
			"::", "&&", "||", "++", "--", "-=", "+=", "/* c */", "// l\n", "@", " ", "\t",
			"\n", "9223372036854775808", "0xFFFFFFFFFFFFFFFF", "x1", "0x", "/"};
		return frags[$urandom_range(0, frags.size() - 1)];
	endfunction

	initial begin
		string s;
		src_item_t it;
		clear_lexer();
		// directed sources
		add_text(" a_1 0x7fffffffffffffff 99999999999999999999 ", 0);
		add_text("0b11 1.5 <<= >>= != :: \"s\\0300t\" \"j\"  \"k\";", 1);
		add_text("0x12345678123456789 \"\\q\" \"ab\ncd\" 1.2.3 /* x **/ / ", 1);
		add_text("\"open", 1);
		add_text("12", 1);
		add_text("/", 1);
		it.b = 8'd0; it.eos = 0; pending_src.push_back(it);
		it.b = 8'd255; it.eos = 1; pending_src.push_back(it);
		// random sources: mostly well formed fragments, some raw noise
		while (pending_src.size() < 440) begin
			s = "";
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 5) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
				else s = {s, pick_fragment(), ($urandom_range(0, 1) ? " " : "")};
			end
			if (s.len() == 0) s = "a";
			add_text(s, $urandom_range(0, 3) == 0);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_src.size() == 0 && !in_valid);
		wait (expected_recs.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_recs.size() == 0) begin
			$display("script_source_tokenizer verification clean");
		end else begin
			$display("script_source_tokenizer verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("script_source_tokenizer verification failed");
		$finish;
	end

endmodule

/* files.f */
hdl/sst_pkg.sv
hdl/script_source_tokenizer.sv
hdl/sst_checker.sv
verif/script_source_tokenizer_test.sv
